>>> sv/assert_macros.svh
// Shared assertion macros for the deframer blocks.
// Each expects clk_i in scope; AMD_ASSERT also expects rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define AMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define AMD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> sv/amd_pkg.sv
package amd_pkg;

  localparam int unsigned MarkerW = 32;
  localparam int unsigned CountW  = 16;
  localparam int unsigned SkipW   = 8;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned RegIdxW = 2;
  localparam int unsigned MaxRes  = 3;

  localparam logic [MarkerW-1:0] MarkerReset = 32'h6974656D;
  localparam logic [CountW-1:0]  ThreshReset = 16'd25;
  localparam logic [SkipW-1:0]   SkipReset   = 8'd12;

  localparam logic [ByteW-1:0] PathLow   = 8'd33;
  localparam logic [ByteW-1:0] PathHigh  = 8'd122;
  localparam logic [ByteW-1:0] RepeatTag = 8'd2;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_START    = 3'd1,
    KIND_PATH     = 3'd2,
    KIND_PATH_END = 3'd3,
    KIND_DATA     = 3'd4
  } amd_kind_e;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_SKIP   = 2'd1,
    PH_PATH   = 2'd2,
    PH_DATA   = 2'd3
  } amd_phase_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_MARKER = 2'd0,
    REG_THRESH = 2'd1,
    REG_SKIP   = 2'd2
  } amd_reg_e;

  typedef struct packed {
    logic [MarkerW-1:0] marker;
    logic [CountW-1:0]  thresh;
    logic [SkipW-1:0]   skip;
  } amd_cfg_t;

  typedef struct packed {
    amd_kind_e         kind;
    logic [ByteW-1:0]  value;
    logic [CountW-1:0] entry_number;
    logic              entry_done;
  } amd_result_t;

  // Up to three results raised by one input byte
  typedef struct packed {
    logic [1:0]                 cnt;
    amd_result_t [MaxRes-1:0]   res;
  } amd_bundle_t;

  function automatic amd_result_t amd_mk(amd_kind_e kind, logic [ByteW-1:0] value,
                                         logic [CountW-1:0] num, logic done);
    amd_result_t r;
    r.kind         = kind;
    r.value        = value;
    r.entry_number = num;
    r.entry_done   = done;
    return r;
  endfunction

  // Window ends in a marker prefix behind zeros, or holds the whole marker
  function automatic logic amd_prefix(logic [MarkerW-1:0] w, logic [MarkerW-1:0] m);
    logic [ByteW-1:0] w0, w1, w2, w3, m0, m1, m2;
    w0 = w[31:24];
    w1 = w[23:16];
    w2 = w[15:8];
    w3 = w[7:0];
    m0 = m[31:24];
    m1 = m[23:16];
    m2 = m[15:8];
    return (w3 == m0 && w2 == '0 && w1 == '0 && w0 == '0) ||
           (w2 == m0 && w3 == m1 && w1 == '0 && w0 == '0) ||
           (w1 == m0 && w2 == m1 && w3 == m2 && w0 == '0) ||
           (w == m);
  endfunction

  // Saturating advance or clear of the run count
  function automatic logic [CountW-1:0] amd_count_next(logic [CountW-1:0] c, logic inc);
    if (!inc) begin
      return '0;
    end else if (c == '1) begin
      return c;
    end
    return c + CountW'(1);
  endfunction

endpackage

>>> sv/amd_if.sv
interface amd_byte_if import amd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface amd_res_if import amd_pkg::*; ();
  logic              valid;
  logic              ready;
  amd_kind_e         kind;
  logic [ByteW-1:0]  value;
  logic [CountW-1:0] entry_number;
  logic              entry_done;
  logic              last;

  modport source (output valid, output kind, output value, output entry_number,
                  output entry_done, output last, input ready);
  modport sink (input valid, input kind, input value, input entry_number,
                input entry_done, input last, output ready);
endinterface

interface amd_cfg_if import amd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RegIdxW-1:0] index;
  logic [MarkerW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/amd_cfg_regs.sv
module amd_cfg_regs import amd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  amd_cfg_if.sink    cfg_i,
  output amd_cfg_t   cfg_o
);

  amd_cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  // Take a write beat into the addressed register; drop unknown indexes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_MARKER: cfg_d.marker = cfg_i.data;
        REG_THRESH: cfg_d.thresh = cfg_i.data[CountW-1:0];
        REG_SKIP:   cfg_d.skip   = cfg_i.data[SkipW-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.marker <= MarkerReset;
      cfg_q.thresh <= ThreshReset;
      cfg_q.skip   <= SkipReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/amd_core.sv
module amd_core import amd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  amd_cfg_t         cfg_i,
  input  logic             fire_i,
  input  logic [ByteW-1:0] data_byte_i,
  output amd_bundle_t      bundle_o
);

  logic [MarkerW-1:0] window_q, window_d;
  logic [CountW-1:0]  zc_q, zc_d;
  amd_phase_e         phase_q, phase_d;
  logic [SkipW-1:0]   skip_q, skip_d;
  logic               ds_q, ds_d;
  logic [ByteW-1:0]   prev_q, prev_d;
  logic [CountW-1:0]  entry_q, entry_d;

  logic [MarkerW-1:0] w_new;
  logic               match, inc, in_path, rep, ds_new, open1, open2;
  logic [CountW-1:0]  c1, c2, entry_inc;
  amd_phase_e         open_phase;
  amd_result_t        start_res, main_res;

  // Shared window, count and open decisions
  always_comb begin
    w_new      = {window_q[MarkerW-ByteW-1:0], data_byte_i};
    match      = (w_new == cfg_i.marker);
    inc        = (data_byte_i == '0) || amd_prefix(w_new, cfg_i.marker);
    c1         = amd_count_next(zc_q, inc);
    c2         = amd_count_next(c1, inc);
    open1      = match && (c1 >= cfg_i.thresh);
    open2      = match && (c2 >= cfg_i.thresh);
    entry_inc  = entry_q + CountW'(1);
    open_phase = (cfg_i.skip == '0) ? PH_PATH : PH_SKIP;
    in_path    = (data_byte_i >= PathLow) && (data_byte_i <= PathHigh);
    rep        = !ds_q && (data_byte_i == RepeatTag);
    ds_new     = ds_q || (data_byte_i != '0);
    start_res  = amd_mk(KIND_START, '0, entry_inc, 1'b0);
    main_res   = ds_new ? amd_mk(KIND_DATA, data_byte_i, entry_q, match)
                        : amd_mk(KIND_NONE, '0, entry_q, 1'b1);
  end

  // Next state and results of one byte
  always_comb begin
    window_d     = w_new;
    zc_d         = zc_q;
    phase_d      = phase_q;
    skip_d       = skip_q;
    ds_d         = ds_q;
    prev_d       = prev_q;
    entry_d      = entry_q;
    bundle_o     = '0;
    unique case (phase_q)
      PH_SEARCH: begin
        zc_d = c1;
        if (open1) begin
          zc_d            = '0;
          entry_d         = entry_inc;
          phase_d         = open_phase;
          skip_d          = cfg_i.skip;
          bundle_o.res[0] = start_res;
          bundle_o.cnt    = 2'd1;
        end
      end
      PH_SKIP: begin
        skip_d = skip_q - SkipW'(skip_q != '0);
        if (skip_d == '0) begin
          phase_d = PH_PATH;
        end
      end
      PH_PATH: begin
        if (in_path) begin
          bundle_o.res[0] = amd_mk(KIND_PATH, data_byte_i, entry_q, 1'b0);
          bundle_o.cnt    = 2'd1;
        end else begin
          bundle_o.res[0] = amd_mk(KIND_PATH_END, '0, entry_q, match);
          bundle_o.cnt    = 2'd1;
          ds_d            = 1'b0;
          prev_d          = '0;
          phase_d         = PH_DATA;
          if (match) begin
            // Close on the terminator, then look for a new entry
            phase_d = PH_SEARCH;
            zc_d    = c1;
            if (open1) begin
              zc_d            = '0;
              entry_d         = entry_inc;
              phase_d         = open_phase;
              skip_d          = cfg_i.skip;
              bundle_o.res[1] = start_res;
              bundle_o.cnt    = 2'd2;
            end
          end
        end
      end
      PH_DATA: begin
        zc_d   = c1;
        ds_d   = ds_new;
        prev_d = data_byte_i;
        if (rep) begin
          // Repeat the previous byte twice; no room left for a start result
          bundle_o.res[0] = amd_mk(KIND_DATA, prev_q, entry_q, 1'b0);
          bundle_o.res[1] = amd_mk(KIND_DATA, prev_q, entry_q, 1'b0);
          bundle_o.res[2] = main_res;
          bundle_o.cnt    = 2'd3;
        end else if (ds_new || match) begin
          bundle_o.res[0] = main_res;
          bundle_o.cnt    = 2'd1;
          if (open2) begin
            bundle_o.res[1] = start_res;
            bundle_o.cnt    = 2'd2;
          end
        end
        if (match) begin
          phase_d = PH_SEARCH;
          zc_d    = c2;
          if (open2) begin
            zc_d    = '0;
            entry_d = entry_inc;
            phase_d = open_phase;
            skip_d  = cfg_i.skip;
          end
        end
      end
      default: phase_d = PH_SEARCH;
    endcase
  end

  // Advance the state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      zc_q     <= '0;
      phase_q  <= PH_SEARCH;
      skip_q   <= '0;
      ds_q     <= 1'b0;
      prev_q   <= '0;
      entry_q  <= '0;
    end else if (fire_i) begin
      window_q <= window_d;
      zc_q     <= zc_d;
      phase_q  <= phase_d;
      skip_q   <= skip_d;
      ds_q     <= ds_d;
      prev_q   <= prev_d;
      entry_q  <= entry_d;
    end
  end

endmodule

>>> sv/amd_serial.sv
`include "assert_macros.svh"

module amd_serial import amd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  amd_bundle_t bundle_i,
  amd_res_if.source   out_o
);

  amd_result_t [MaxRes-1:0] res_q;
  logic [1:0]               cnt_q, cnt_d;
  logic [1:0]               idx_q, idx_d;
  logic                     pop, is_last, load;
  amd_result_t              cur;

  assign cur     = res_q[idx_q];
  assign is_last = (idx_q == 2'(cnt_q - 2'd1));
  assign pop     = out_o.valid && out_o.ready;

  // Free when empty or when the final result leaves this cycle
  assign in_ready_o = (cnt_q == '0) || (pop && is_last);
  assign load       = in_valid_i && in_ready_o && (bundle_i.cnt != '0);

  assign out_o.valid        = (cnt_q != '0);
  assign out_o.kind         = cur.kind;
  assign out_o.value        = cur.value;
  assign out_o.entry_number = cur.entry_number;
  assign out_o.entry_done   = cur.entry_done;
  assign out_o.last         = is_last;

  // Step through the held results, reload on a new beat
  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (pop) begin
      if (is_last) begin
        cnt_d = '0;
        idx_d = '0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
    if (load) begin
      cnt_d = bundle_i.cnt;
      idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= bundle_i.res;
    end
  end

  `AMD_ASSERT_ALWAYS(a_idx_in_range, (cnt_q == '0) || (idx_q < cnt_q), "result index past count")
  `AMD_ASSERT(a_hold_on_stall, (cnt_q != '0 && !out_o.ready) |=> ($stable(idx_q) && $stable(cnt_q)), "held results moved under stall")
  `AMD_ASSERT(a_load_when_free, load |-> ((cnt_q == '0) || (pop && is_last)), "new results overwrote pending ones")

endmodule

>>> sv/archive_marker_deframer_unit.sv
// Channel  Dir  Payload                                        Accepted when
// in_i     in   data_byte[7:0]                                 valid && ready
// out_o    out  kind[2:0] value[7:0] entry_number[15:0]        valid && ready
//               entry_done last
// cfg_i    in   index[1:0] data[31:0]                          valid && ready
//
// One byte is decoded per cycle while in_i.ready is high; its results land in
// the result register in the next cycle. A byte raises zero to three results,
// sent one a cycle while out_o is ready; a new byte is taken as the last leaves.
// A stall on out_o holds the result register and lowers in_i.ready.
// Reset clears the window, counters and phase; the registers take their
// defaults (marker "item", threshold 25, skip 12). cfg_i is always ready.
module archive_marker_deframer_unit import amd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  amd_byte_if.sink  in_i,
  amd_res_if.source out_o,
  amd_cfg_if.sink   cfg_i
);

  amd_cfg_t    cfg;
  amd_bundle_t bundle;
  logic        in_ready;
  logic        fire;

  assign in_i.ready = in_ready;
  assign fire       = in_i.valid && in_ready;

  amd_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  amd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .fire_i      (fire),
    .data_byte_i (in_i.data_byte),
    .bundle_o    (bundle)
  );

  amd_serial u_serial (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .bundle_i   (bundle),
    .out_o      (out_o)
  );

endmodule
